### hw/rtl/i2c_bb_pkg.sv
// ============================================================================
// i2c_bb_pkg - shared types and codes for the bit-banged I2C master
// Command codes, the one-hot operation type and the tick record that
// travels from the front end to the sequencer.
// ============================================================================
package i2c_bb_pkg;

    // Command codes as carried on the input stream
    localparam logic [2:0] CMD_NONE  = 3'd0;
    localparam logic [2:0] CMD_START = 3'd1;
    localparam logic [2:0] CMD_STOP  = 3'd2;
    localparam logic [2:0] CMD_WRITE = 3'd3;
    localparam logic [2:0] CMD_READ  = 3'd4;

    // Operation being sequenced, one-hot
    typedef enum logic [4:0] {
        OP_IDLE  = 5'b00001,
        OP_START = 5'b00010,
        OP_STOP  = 5'b00100,
        OP_WRITE = 5'b01000,
        OP_READ  = 5'b10000
    } op_t;

    // One decoded tick
    typedef struct packed {
        op_t        new_op;     // op to launch if idle, OP_IDLE for none
        logic       cmd_nz;     // any nonzero command code
        logic [7:0] tx_byte;
        logic       rd_nack;
        logic       sda_in;
    } tick_t;

endpackage

### hw/rtl/i2c_bb_front.sv
// ============================================================================
// i2c_bb_front - input acceptance, command decode and tick queue
// Decodes each incoming item and holds it in a two-entry queue until the
// sequencer takes it.
// ============================================================================
module i2c_bb_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [15:0]        s_tdata,   // cmd[2:0], tx_byte[10:3], rd_nack[11],
                                          // sda_in[12], zero pad[15:13]
    output logic               q_valid,
    output i2c_bb_pkg::tick_t  q_tick,
    input  logic               q_pop
);

    i2c_bb_pkg::tick_t tick_in;
    i2c_bb_pkg::tick_t queue_reg [2];
    logic              wr_ptr_reg, wr_ptr_next;
    logic              rd_ptr_reg, rd_ptr_next;
    logic [1:0]        count_reg, count_next;
    logic              push;
    logic              pop;
    logic [2:0]        cmd;

    assign cmd = s_tdata[2:0];

    always_comb
    begin
        tick_in.cmd_nz  = (cmd != i2c_bb_pkg::CMD_NONE);
        tick_in.tx_byte = s_tdata[10:3];
        tick_in.rd_nack = s_tdata[11];
        tick_in.sda_in  = s_tdata[12];
        unique case (cmd)
            i2c_bb_pkg::CMD_START: tick_in.new_op = i2c_bb_pkg::OP_START;
            i2c_bb_pkg::CMD_STOP:  tick_in.new_op = i2c_bb_pkg::OP_STOP;
            i2c_bb_pkg::CMD_WRITE: tick_in.new_op = i2c_bb_pkg::OP_WRITE;
            i2c_bb_pkg::CMD_READ:  tick_in.new_op = i2c_bb_pkg::OP_READ;
            default:               tick_in.new_op = i2c_bb_pkg::OP_IDLE;
        endcase
    end

    assign s_tready = (count_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != 2'd0);
    assign pop      = q_pop && q_valid;
    assign q_tick   = queue_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= tick_in;
        end
    end

endmodule

### hw/rtl/i2c_bb_seq.sv
// ============================================================================
// i2c_bb_seq - SCL/SDA phase sequencer with registered result
// Runs one bus phase per queued tick and presents the line levels and
// status in an output register.
// ============================================================================
module i2c_bb_seq
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  i2c_bb_pkg::tick_t  q_tick,
    output logic               q_pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [15:0]        m_tdata
);

    i2c_bb_pkg::op_t op_reg, op_next;
    logic [2:0]      phase_reg, phase_next;
    logic [3:0]      bit_reg, bit_next;
    logic [7:0]      shift_reg, shift_next;
    logic            scl_reg, scl_next;
    logic            sda_reg, sda_next;
    logic            ack_result_reg, ack_result_next;
    logic            ack_pending_reg, ack_pending_next;
    logic [7:0]      rx_hold_reg, rx_hold_next;
    logic            out_valid_reg, out_valid_next;
    logic [15:0]     out_data_reg, out_data_next;
    logic            fire;
    logic            run;
    logic            fin;
    logic            ignored;
    logic [2:0]      p;

    assign fire     = q_valid && (!out_valid_reg || m_tready);
    assign q_pop    = fire;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_comb
    begin
        op_next          = op_reg;
        phase_next       = phase_reg;
        bit_next         = bit_reg;
        shift_next       = shift_reg;
        scl_next         = scl_reg;
        sda_next         = sda_reg;
        ack_result_next  = ack_result_reg;
        ack_pending_next = ack_pending_reg;
        rx_hold_next     = rx_hold_reg;
        run              = 1'b0;
        fin              = 1'b0;
        ignored          = 1'b0;
        p                = 3'd0;

        if (fire)
        begin
            if (op_reg != i2c_bb_pkg::OP_IDLE)
            begin
                ignored = q_tick.cmd_nz;
                run     = 1'b1;
            end
            else if (q_tick.new_op != i2c_bb_pkg::OP_IDLE)
            begin
                op_next    = q_tick.new_op;
                phase_next = 3'd0;
                bit_next   = 4'd0;
                if (q_tick.new_op == i2c_bb_pkg::OP_WRITE)
                begin
                    shift_next = q_tick.tx_byte;
                end
                if (q_tick.new_op == i2c_bb_pkg::OP_READ)
                begin
                    shift_next       = 8'd0;
                    ack_pending_next = q_tick.rd_nack;
                end
                run = 1'b1;
            end
        end

        if (run)
        begin
            p = phase_next;
            unique case (op_next)
                i2c_bb_pkg::OP_START:
                begin
                    priority if (p == 3'd0)
                    begin
                        sda_next = 1'b1;
                        scl_next = 1'b1;
                    end
                    else if (p == 3'd1)
                    begin
                        sda_next = 1'b0;
                    end
                    else
                    begin
                        scl_next = 1'b0;
                        fin      = 1'b1;
                    end
                    phase_next = p + 3'd1;
                end
                i2c_bb_pkg::OP_STOP:
                begin
                    // first phase leaves the lines as they are
                    if (p == 3'd1)
                    begin
                        scl_next = 1'b1;
                    end
                    else if (p >= 3'd2)
                    begin
                        sda_next = 1'b1;
                        fin      = 1'b1;
                    end
                    phase_next = p + 3'd1;
                end
                i2c_bb_pkg::OP_WRITE:
                begin
                    priority if (bit_next == 4'd0)
                    begin
                        // lead-in phase before the first data bit
                        bit_next   = 4'd1;
                        phase_next = 3'd0;
                    end
                    else if (bit_next <= 4'd8)
                    begin
                        priority if (p == 3'd0)
                        begin
                            sda_next   = shift_next[7];
                            phase_next = 3'd1;
                        end
                        else if (p == 3'd1)
                        begin
                            scl_next   = 1'b1;
                            phase_next = 3'd2;
                        end
                        else
                        begin
                            scl_next   = 1'b0;
                            shift_next = {shift_next[6:0], 1'b0};
                            bit_next   = bit_next + 4'd1;
                            phase_next = 3'd0;
                        end
                    end
                    else
                    begin
                        // ACK slot: release SDA, clock, sample, end low
                        priority if (p == 3'd0)
                        begin
                            sda_next = 1'b1;
                        end
                        else if (p == 3'd1)
                        begin
                            scl_next = 1'b0;
                        end
                        else if (p == 3'd2)
                        begin
                            scl_next = 1'b1;
                        end
                        else if (p == 3'd3)
                        begin
                            ack_result_next = q_tick.sda_in;
                        end
                        else if (p == 3'd4)
                        begin
                            scl_next = 1'b0;
                        end
                        else
                        begin
                            sda_next = 1'b0;
                            fin      = 1'b1;
                        end
                        phase_next = p + 3'd1;
                    end
                end
                i2c_bb_pkg::OP_READ:
                begin
                    if (bit_next <= 4'd7)
                    begin
                        priority if (p == 3'd0)
                        begin
                            if (bit_next == 4'd0)
                            begin
                                sda_next = 1'b1;
                            end
                            phase_next = 3'd1;
                        end
                        else if (p == 3'd1)
                        begin
                            scl_next   = 1'b0;
                            phase_next = 3'd2;
                        end
                        else if (p == 3'd2)
                        begin
                            scl_next   = 1'b1;
                            phase_next = 3'd3;
                        end
                        else
                        begin
                            shift_next = {shift_next[6:0], q_tick.sda_in};
                            bit_next   = bit_next + 4'd1;
                            phase_next = 3'd0;
                        end
                    end
                    else
                    begin
                        // ACK/NACK slot driven by the master
                        priority if (p == 3'd0 || p == 3'd1)
                        begin
                            scl_next = 1'b0;
                        end
                        else if (p == 3'd2)
                        begin
                            sda_next = ack_pending_next;
                            scl_next = 1'b0;
                        end
                        else if (p == 3'd3)
                        begin
                            scl_next = 1'b1;
                        end
                        else if (p == 3'd4)
                        begin
                            scl_next = 1'b0;
                        end
                        else
                        begin
                            sda_next     = 1'b1;
                            rx_hold_next = shift_next;
                            fin          = 1'b1;
                        end
                        phase_next = p + 3'd1;
                    end
                end
                default:
                begin
                    fin = 1'b1;
                end
            endcase

            if (fin)
            begin
                op_next    = i2c_bb_pkg::OP_IDLE;
                phase_next = 3'd0;
                bit_next   = 4'd0;
            end
        end
    end

    always_comb
    begin
        out_valid_next = fire || (out_valid_reg && !m_tready);
        out_data_next  = out_data_reg;
        if (fire)
        begin
            out_data_next = {2'b00, ignored, ack_result_next, rx_hold_next, fin,
                             (op_next != i2c_bb_pkg::OP_IDLE), sda_next, scl_next};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg          <= i2c_bb_pkg::OP_IDLE;
            phase_reg       <= 3'd0;
            bit_reg         <= 4'd0;
            shift_reg       <= 8'd0;
            scl_reg         <= 1'b1;
            sda_reg         <= 1'b1;
            ack_result_reg  <= 1'b0;
            ack_pending_reg <= 1'b0;
            rx_hold_reg     <= 8'd0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            op_reg          <= op_next;
            phase_reg       <= phase_next;
            bit_reg         <= bit_next;
            shift_reg       <= shift_next;
            scl_reg         <= scl_next;
            sda_reg         <= sda_next;
            ack_result_reg  <= ack_result_next;
            ack_pending_reg <= ack_pending_next;
            rx_hold_reg     <= rx_hold_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

endmodule

### hw/rtl/i2c_bitbang_master.sv
// ============================================================================
// i2c_bitbang_master - tick-driven bit-banged I2C master
// Front end decodes and queues ticks, sequencer walks the bus phases.
// ============================================================================
// Usage:
//   Each item on the s_ stream is one bus delay interval (a tick). While the
//   master is idle, a tick may carry a command (start, stop, write byte with
//   ACK receive, read byte with ACK/NACK send); the first phase of that
//   command is carried out on the same tick. Every tick also carries the SDA
//   level sampled by the pad during that interval.
//   For every tick exactly one item leaves on the m_ stream with the SCL and
//   SDA drive levels (0 pulled low, 1 released), busy, done, the last read
//   byte, the last write ACK and a flag for a command dropped while busy.
//   Path: an accepted item passes the two-entry tick queue and then the
//   output register before its result is offered on m_.
//   Throughput: one tick per cycle while the output is not stalled, as the
//   sequencer steps one bus phase per tick.
//   Stall: if m_tready is low the result holds in the output register, the
//   queue absorbs up to two more ticks, then s_tready drops.
//   Reset: lines released (1), idle, rx_byte and ack_seen cleared, queue
//   empty, no result pending.
// ============================================================================
module i2c_bitbang_master
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // cmd[2:0], tx_byte[10:3], rd_nack[11],
                                   // sda_in[12], zero pad[15:13]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // scl_out[0], sda_out[1], busy_res[2],
                                   // done_res[3], rx_byte[11:4], ack_seen[12],
                                   // cmd_ignored[13], zero pad[15:14]
);

    logic              q_valid;
    logic              q_pop;
    i2c_bb_pkg::tick_t q_tick;

    // Front end: decode cmd into an op, queue the tick
    i2c_bb_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_valid  (q_valid),
        .q_tick   (q_tick),
        .q_pop    (q_pop)
    );

    // Back end: one bus phase per tick, result registered
    i2c_bb_seq u_seq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_tick   (q_tick),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

### hw/rtl/i2c_bb_checker.sv
// ============================================================================
// i2c_bb_checker - port-level assertions for the I2C master
// Watches the stream ports of the top level; bound in below.
// ============================================================================
module i2c_bb_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // a finished command never reports busy
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[3] && m_tdata[2]))
        else $error("done and busy together");

    // input side only backs up behind a held result
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result held");

    // a tick accepted with the output free is answered once it has passed the queue and the output register
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !m_tvalid && !$past(s_tvalid && s_tready)
        |-> ##2 m_tvalid)
        else $error("tick not answered");

    // unused padding
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[15:14] == 2'b00)
        else $error("pad bits set");

endmodule

bind i2c_bitbang_master i2c_bb_checker u_i2c_bb_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### sim/i2c_bitbang_master_test.sv
`timescale 1ns / 100ps
// ============================================================================
// i2c_bitbang_master_test - self-checking bench for the bit-banged I2C master
// Streams bus ticks carrying start, stop, write and read commands with random
// SDA samples, mirrors the phase sequencer tick by tick and compares every
// output item (line levels, busy, done, read byte, ACK, dropped flag).
// ============================================================================
module i2c_bitbang_master_test;

    // SDA pattern used for the ticks of one command
    localparam int SDA_LOW    = 0;
    localparam int SDA_HIGH   = 1;
    localparam int SDA_RANDOM = 2;

    localparam int MAX_PRINTED = 50;     // cap on mismatch lines

    // One tick as sent on the s_ stream
    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] tx;
        logic       ack_lvl;
        logic       sda;
    } tick_item_t;

    // One output item, laid out as m_tdata[13:0] (MSB first here)
    typedef struct packed {
        logic       ignored;
        logic       ack;
        logic [7:0] rx_byte;
        logic       done;
        logic       busy;
        logic       sda;
        logic       scl;
    } bus_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;     // cmd[2:0], tx_byte[10:3], rd_nack[11],
                                   // sda_in[12], zero pad[15:13]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;          // scl_out[0], sda_out[1], busy_res[2],
                                   // done_res[3], rx_byte[11:4], ack_seen[12],
                                   // cmd_ignored[13], zero pad[15:14]

    i2c_bitbang_master dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Sequencer mirror: line levels, phase counters and the byte shifter
    // ------------------------------------------------------------------
    i2c_bb_pkg::op_t bus_op = i2c_bb_pkg::OP_IDLE;
    logic [2:0] phase    = 3'd0;
    logic [3:0] bit_cnt  = 4'd0;
    logic [7:0] shifter  = 8'd0;
    logic       scl_q    = 1'b1;
    logic       sda_q    = 1'b1;
    logic       ack_q    = 1'b0;
    logic       nack_lvl = 1'b0;     // level to send in the read ACK slot
    logic [7:0] rx_q     = 8'd0;

    tick_item_t  pending_ticks[$];   // stimulus not yet offered
    bus_result_t line_states[$];     // predicted output items, oldest first

    int errors      = 0;
    int checked_cnt = 0;
    int dropped_cnt = 0;
    int nack_cnt    = 0;
    int n_start     = 0;
    int n_stop      = 0;
    int n_write     = 0;
    int n_read      = 0;
    int n_other     = 0;

    // Runs one phase of the active operation; returns 1 when it finishes.
    function automatic logic step_bus(logic sda);
        logic fin;
        fin = 1'b0;
        case (bus_op)
            i2c_bb_pkg::OP_START:
            begin
                if (phase == 3'd0)
                begin
                    sda_q = 1'b1;
                    scl_q = 1'b1;
                end
                else if (phase == 3'd1)
                    sda_q = 1'b0;
                else
                begin
                    scl_q = 1'b0;
                    fin = 1'b1;
                end
                phase = phase + 3'd1;
            end
            i2c_bb_pkg::OP_STOP:
            begin
                if (phase == 3'd1)
                    scl_q = 1'b1;
                else if (phase >= 3'd2)
                begin
                    sda_q = 1'b1;
                    fin = 1'b1;
                end
                phase = phase + 3'd1;
            end
            i2c_bb_pkg::OP_WRITE:
            begin
                // one lead-in tick, three ticks per data bit, six for the ACK slot
                if (bit_cnt == 4'd0)
                begin
                    bit_cnt = 4'd1;
                    phase = 3'd0;
                end
                else if (bit_cnt <= 4'd8)
                begin
                    case (phase)
                        3'd0:
                        begin
                            sda_q = shifter[7];
                            phase = 3'd1;
                        end
                        3'd1:
                        begin
                            scl_q = 1'b1;
                            phase = 3'd2;
                        end
                        default:
                        begin
                            scl_q = 1'b0;
                            shifter = shifter << 1;
                            bit_cnt = bit_cnt + 4'd1;
                            phase = 3'd0;
                        end
                    endcase
                end
                else
                begin
                    case (phase)
                        3'd0: sda_q = 1'b1;
                        3'd1: scl_q = 1'b0;
                        3'd2: scl_q = 1'b1;
                        3'd3: ack_q = sda;
                        3'd4: scl_q = 1'b0;
                        default:
                        begin
                            sda_q = 1'b0;
                            fin = 1'b1;
                        end
                    endcase
                    phase = phase + 3'd1;
                end
            end
            i2c_bb_pkg::OP_READ:
            begin
                // four ticks per data bit, then six for the ACK slot
                if (bit_cnt <= 4'd7)
                begin
                    case (phase)
                        3'd0:
                        begin
                            if (bit_cnt == 4'd0)
                                sda_q = 1'b1;
                            phase = 3'd1;
                        end
                        3'd1:
                        begin
                            scl_q = 1'b0;
                            phase = 3'd2;
                        end
                        3'd2:
                        begin
                            scl_q = 1'b1;
                            phase = 3'd3;
                        end
                        default:
                        begin
                            shifter = {shifter[6:0], sda};
                            bit_cnt = bit_cnt + 4'd1;
                            phase = 3'd0;
                        end
                    endcase
                end
                else
                begin
                    case (phase)
                        3'd0, 3'd1: scl_q = 1'b0;
                        3'd2:
                        begin
                            sda_q = nack_lvl;
                            scl_q = 1'b0;
                        end
                        3'd3: scl_q = 1'b1;
                        3'd4: scl_q = 1'b0;
                        default:
                        begin
                            sda_q = 1'b1;
                            rx_q = shifter;
                            fin = 1'b1;
                        end
                    endcase
                    phase = phase + 3'd1;
                end
            end
            default: fin = 1'b1;
        endcase
        if (fin)
        begin
            bus_op = i2c_bb_pkg::OP_IDLE;
            phase = 3'd0;
            bit_cnt = 4'd0;
        end
        return fin;
    endfunction

    // Applies one accepted tick to the mirror and returns the output item.
    function automatic bus_result_t advance_bus(logic [2:0] cmd, logic [7:0] tx,
                                                logic ack_lvl, logic sda);
        bus_result_t r;
        logic        fin;
        logic        dropped;
        fin = 1'b0;
        dropped = 1'b0;
        if (bus_op != i2c_bb_pkg::OP_IDLE)
        begin
            // any nonzero code while busy is dropped, the sequence goes on
            dropped = (cmd != i2c_bb_pkg::CMD_NONE);
            fin = step_bus(sda);
        end
        else
        begin
            case (cmd)
                i2c_bb_pkg::CMD_START: bus_op = i2c_bb_pkg::OP_START;
                i2c_bb_pkg::CMD_STOP:  bus_op = i2c_bb_pkg::OP_STOP;
                i2c_bb_pkg::CMD_WRITE: bus_op = i2c_bb_pkg::OP_WRITE;
                i2c_bb_pkg::CMD_READ:  bus_op = i2c_bb_pkg::OP_READ;
                default:               bus_op = i2c_bb_pkg::OP_IDLE; // codes 5..7 too
            endcase
            if (bus_op != i2c_bb_pkg::OP_IDLE)
            begin
                phase = 3'd0;
                bit_cnt = 4'd0;
                if (bus_op == i2c_bb_pkg::OP_WRITE)
                    shifter = tx;
                if (bus_op == i2c_bb_pkg::OP_READ)
                begin
                    shifter = 8'd0;
                    nack_lvl = ack_lvl;
                end
                // first phase runs on the accepting tick
                fin = step_bus(sda);
            end
        end
        if (dropped)
            dropped_cnt++;
        if (fin && cmd == i2c_bb_pkg::CMD_NONE && ack_q && phase == 3'd0 && sda_q == 1'b0)
            nack_cnt++;
        r.scl     = scl_q;
        r.sda     = sda_q;
        r.busy    = (bus_op != i2c_bb_pkg::OP_IDLE);
        r.done    = fin;
        r.rx_byte = rx_q;
        r.ack     = ack_q;
        r.ignored = dropped;
        return r;
    endfunction

    // Gap length for either side: mostly none or short, a few long, and
    // now and then a calm stretch with no gaps at all.
    function automatic int next_gap(inout int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2)
        begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 25);
    endfunction

    task automatic report(string what, int got, int want);
        if (errors < MAX_PRINTED)
            $display("ERROR: item %0d %s: got 0x%0h, expected 0x%0h",
                     checked_cnt, what, got, want);
        errors++;
    endtask

    // Queues one command tick followed by the ticks that its sequence takes.
    // noise_pct is the chance that a busy tick carries a stray command.
    task automatic queue_cmd(input logic [2:0] cmd, input logic [7:0] tx,
                             input logic ack_lvl, input int sda_mode,
                             input int noise_pct);
        int         len;
        tick_item_t t;
        case (cmd)
            i2c_bb_pkg::CMD_START:
            begin
                len = 3;
                n_start++;
            end
            i2c_bb_pkg::CMD_STOP:
            begin
                len = 3;
                n_stop++;
            end
            i2c_bb_pkg::CMD_WRITE:
            begin
                len = 31;
                n_write++;
            end
            i2c_bb_pkg::CMD_READ:
            begin
                len = 38;
                n_read++;
            end
            default:
            begin
                len = 1;
                n_other++;
            end
        endcase
        for (int i = 0; i < len; i++)
        begin
            if (i == 0)
            begin
                t.cmd = cmd;
                t.tx = tx;
                t.ack_lvl = ack_lvl;
            end
            else
            begin
                t.cmd = ($urandom_range(0, 99) < noise_pct) ?
                        3'($urandom_range(1, 7)) : i2c_bb_pkg::CMD_NONE;
                t.tx = 8'($urandom);
                t.ack_lvl = 1'($urandom);
            end
            t.sda = (sda_mode == SDA_RANDOM) ? 1'($urandom) : sda_mode[0];
            pending_ticks.push_back(t);
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: offers queued ticks with random gaps, predicts on accept
    // ------------------------------------------------------------------
    int         send_gap  = 0;
    int         send_calm = 0;
    tick_item_t next_tick;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                line_states.push_back(advance_bus(s_tdata[2:0], s_tdata[10:3],
                                                  s_tdata[11], s_tdata[12]));
            // the slot is free when nothing is offered or the offer was taken
            if (!s_tvalid || s_tready)
            begin
                if (send_gap != 0)
                begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_ticks.size() != 0)
                begin
                    next_tick = pending_ticks.pop_front();
                    s_tdata <= {3'b000, next_tick.sda, next_tick.ack_lvl,
                                next_tick.tx, next_tick.cmd};
                    s_tvalid <= 1'b1;
                    send_gap = next_gap(send_calm);
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: random back-pressure, every output item checked in order
    // ------------------------------------------------------------------
    int          stall_left = 0;
    int          recv_calm  = 0;
    bus_result_t got_res;
    bus_result_t want_res;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got_res = m_tdata[13:0];
                if (line_states.size() == 0)
                    report("arrived with nothing expected", m_tdata, 0);
                else
                begin
                    want_res = line_states.pop_front();
                    if (got_res.scl != want_res.scl)
                        report("scl_out", got_res.scl, want_res.scl);
                    if (got_res.sda != want_res.sda)
                        report("sda_out", got_res.sda, want_res.sda);
                    if (got_res.busy != want_res.busy)
                        report("busy_res", got_res.busy, want_res.busy);
                    if (got_res.done != want_res.done)
                        report("done_res", got_res.done, want_res.done);
                    if (got_res.rx_byte != want_res.rx_byte)
                        report("rx_byte", got_res.rx_byte, want_res.rx_byte);
                    if (got_res.ack != want_res.ack)
                        report("ack_seen", got_res.ack, want_res.ack);
                    if (got_res.ignored != want_res.ignored)
                        report("cmd_ignored", got_res.ignored, want_res.ignored);
                    if (m_tdata[15:14] != 2'b00)
                        report("pad bits", m_tdata[15:14], 0);
                end
                checked_cnt++;
            end
            if (stall_left != 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                stall_left = next_gap(recv_calm);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus, reset and end of run
    // ------------------------------------------------------------------
    initial
    begin
        // Directed: idle ticks, unused codes while idle, a full transfer
        // with both byte extremes, ACK and NACK in each direction, and a
        // write that is hammered by stray commands throughout.
        queue_cmd(i2c_bb_pkg::CMD_NONE, 8'h00, 1'b0, SDA_RANDOM, 0);
        queue_cmd(3'd5, 8'hFF, 1'b1, SDA_HIGH, 0);
        queue_cmd(3'd6, 8'h00, 1'b0, SDA_LOW, 0);
        queue_cmd(3'd7, 8'hA5, 1'b1, SDA_RANDOM, 0);
        queue_cmd(i2c_bb_pkg::CMD_START, 8'h00, 1'b0, SDA_RANDOM, 100);
        queue_cmd(i2c_bb_pkg::CMD_WRITE, 8'hFF, 1'b0, SDA_LOW, 0);    // slave ACKs
        queue_cmd(i2c_bb_pkg::CMD_WRITE, 8'h00, 1'b1, SDA_HIGH, 100); // NACK, noise
        queue_cmd(i2c_bb_pkg::CMD_READ, 8'hFF, 1'b0, SDA_HIGH, 0);    // 0xFF, ACK
        queue_cmd(i2c_bb_pkg::CMD_READ, 8'h00, 1'b1, SDA_LOW, 0);     // 0x00, NACK
        queue_cmd(i2c_bb_pkg::CMD_STOP, 8'h00, 1'b0, SDA_RANDOM, 100);
        queue_cmd(i2c_bb_pkg::CMD_STOP, 8'h00, 1'b0, SDA_RANDOM, 0);  // idle bus

        // Random: mostly well-formed transactions with random bytes and
        // SDA samples, the rest lone commands and junk codes.
        while (pending_ticks.size() < 1000)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                queue_cmd(i2c_bb_pkg::CMD_START, 8'($urandom), 1'($urandom),
                          SDA_RANDOM, 5);
                repeat ($urandom_range(1, 3))
                begin
                    if ($urandom_range(0, 1))
                        queue_cmd(i2c_bb_pkg::CMD_WRITE, 8'($urandom), 1'($urandom),
                                  SDA_RANDOM, 5);
                    else
                        queue_cmd(i2c_bb_pkg::CMD_READ, 8'($urandom), 1'($urandom),
                                  SDA_RANDOM, 5);
                end
                queue_cmd(i2c_bb_pkg::CMD_STOP, 8'($urandom), 1'($urandom),
                          SDA_RANDOM, 5);
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                    queue_cmd(3'($urandom_range(0, 7)), 8'($urandom),
                              1'($urandom), SDA_RANDOM, 30);
            end
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // drain: all ticks taken, all items back, then a final check that none are still expected
        while (pending_ticks.size() != 0 || s_tvalid)
            @(posedge clk);
        while (line_states.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (line_states.size() != 0)
            report("items still expected", line_states.size(), 0);

        $display("Checked %0d items: %0d start, %0d stop, %0d write, %0d read,",
                 checked_cnt, n_start, n_stop, n_write, n_read);
        $display("  %0d idle or unused-code ticks, %0d commands dropped while busy",
                 n_other, dropped_cnt);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Hang guard, far beyond the slowest legal run
    initial
    begin
        #1000000;
        $display("Timeout with %0d ticks unsent, %0d items outstanding",
                 pending_ticks.size(), line_states.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule
